### rtl/ssfs_pkg.sv
// Shared types and constants for the smoothstep fade sequencer.
// No dependencies; every other file of the block imports this package.
package ssfs_pkg;

    localparam int DT_W      = 17;
    localparam int DUR_W     = 24;
    localparam int EL_W      = 25;
    localparam int PHASE_W   = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [DUR_W-1:0] FADE_TIME_RST = 24'd500000;
    localparam logic [EL_W-1:0]  EL_MAX        = {EL_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 1'b1;

    // Item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    // progress = (PROG_MUL * t + PROG_BIAS) / PROG_DIV while fading out
    localparam int PROG_MUL  = 15;
    localparam int PROG_BIAS = 50;
    localparam int PROG_DIV  = 100;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 2'd0,
        PH_FADE_OUT = 2'd1,
        PH_LOAD     = 2'd2,
        PH_FADE_IN  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RATIO,
        ST_DIVR,
        ST_SQ,
        ST_CUBE,
        ST_APPLY,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take_item;
        logic start_fade;
        logic load_step;
        logic add_time;
        logic t_one;
        logic div_ratio;
        logic take_quot;
        logic square;
        logic cube;
        logic scale_prog;
        logic apply;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic   is_begin;
        logic   has_target;
        phase_t phase;
        logic   t_sat;
        logic   div_busy;
    } dp_status_t;

endpackage

### rtl/ssfs_div.sv
// Restoring divider for the time ratio: one quotient bit per cycle.
// Depends on ssfs_pkg for the duration width.
module ssfs_div #(
    parameter int NUM_W = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssfs_pkg::DUR_W-1:0]    rem_init,
    input  logic [NUM_W-1:0]              numer,
    input  logic [$clog2(NUM_W+1)-1:0]    nbits,
    input  logic [ssfs_pkg::DUR_W-1:0]    divisor,
    output logic                          busy,
    output logic [NUM_W-1:0]              quot
);
    import ssfs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W+1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DUR_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DUR_W-1:0] dvs_reg, dvs_next;
    logic [DUR_W:0]   trial;
    logic [DUR_W:0]   diff;
    logic             ge;

    // remainder stays below the divisor, so the shifted trial fits DUR_W+1 bits
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next  = nbits;
            rem_next  = rem_init;
            num_next  = numer;
            quot_next = '0;
            dvs_next  = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - CNT_W'(1);
            rem_next  = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

### rtl/ssfs_datapath.sv
// Datapath of the fade sequencer: registers, elapsed time, ratio, smoothstep, levels.
// Depends on ssfs_pkg and instantiates ssfs_div.
module ssfs_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssfs_pkg::DUR_W-1:0]        cfg_data,
    input  logic                              s_op,
    input  logic signed [ssfs_pkg::DT_W-1:0]  s_dt,
    input  logic                              s_has_target,
    input  ssfs_pkg::dp_cmd_t                 cmd,
    output ssfs_pkg::dp_status_t              status,
    output logic [FRAC_BITS:0]                alpha_level,
    output logic [FRAC_BITS:0]                prog_level,
    output ssfs_pkg::phase_t                  phase,
    output logic                              swap
);
    import ssfs_pkg::*;

    localparam int LVL_W = FRAC_BITS + 1;
    localparam int NUM_W = FRAC_BITS + 4;
    localparam int CNT_W = $clog2(FRAC_BITS+1);
    localparam int SQ_W  = 2 * LVL_W;
    localparam int CB_W  = 2 * LVL_W + 1;
    // floor(x / PROG_DIV) = (x * PROG_RCP) >> PK, exact for any x below 2^NUM_W
    localparam int PK    = NUM_W + 7;
    localparam int RCP_W = NUM_W + 1;
    localparam int PP_W  = NUM_W + RCP_W;
    localparam int PQ_W  = NUM_W - 6;
    localparam logic [RCP_W-1:0] PROG_RCP =
        RCP_W'(((64'd1 << PK) + 64'(PROG_DIV) - 64'd1) / 64'(PROG_DIV));
    localparam logic [LVL_W-1:0] ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LVL_W-1:0] SIX_TENTHS = LVL_W'((3 * (2 ** FRAC_BITS) + 2) / 5);
    localparam int HALF = 2 ** (FRAC_BITS - 1);

    logic [DUR_W-1:0] fade_out_reg, fade_out_next;
    logic [DUR_W-1:0] fade_in_reg, fade_in_next;
    phase_t           phase_reg, phase_next;
    logic [EL_W-1:0]  el_reg, el_next;
    logic [LVL_W-1:0] alpha_reg, alpha_next;
    logic [LVL_W-1:0] prog_reg, prog_next;
    logic             swap_done_reg, swap_done_next;
    logic             swap_reg, swap_next;
    logic             op_reg, op_next;
    logic [DT_W-1:0]  dt_reg, dt_next;
    logic             tgt_reg, tgt_next;
    logic [LVL_W-1:0] t_reg, t_next;
    logic [LVL_W-1:0] t2_reg, t2_next;
    logic [LVL_W-1:0] s_reg, s_next;
    logic [LVL_W-1:0] pq_reg, pq_next;

    logic [DUR_W-1:0] dur;
    logic [DT_W-2:0]  d_pos;
    logic [EL_W:0]    el_sum;
    logic [SQ_W-1:0]  sq_rnd;
    logic [LVL_W:0]   cube_mul;
    logic [CB_W-1:0]  cube_rnd;
    logic [LVL_W:0]   s_raw;
    logic [NUM_W-1:0] pnum;
    logic [PP_W-1:0]  pprod;
    logic             t_full;

    logic                 div_start;
    logic [DUR_W-1:0]     div_rem;
    logic [FRAC_BITS-1:0] div_num;
    logic [CNT_W-1:0]     div_nbits;
    logic [DUR_W-1:0]     div_dvs;
    logic                 div_busy;
    logic [FRAC_BITS-1:0] div_quot;

    assign dur    = (phase_reg == PH_FADE_OUT) ? fade_out_reg : fade_in_reg;
    assign d_pos  = dt_reg[DT_W-1] ? '0 : dt_reg[DT_W-2:0];
    assign el_sum = {1'b0, el_reg} + (EL_W+1)'(d_pos);
    assign t_full = (t_reg == ONE);

    // t^2 rounded back to Q1.FRAC_BITS
    assign sq_rnd = SQ_W'(t_reg * t_reg) + SQ_W'(HALF);
    // t^2 * (3 - 2t), rounded
    assign cube_mul = {ONE, 1'b0} + {1'b0, ONE} - {t_reg, 1'b0};
    assign cube_rnd = CB_W'(t2_reg * cube_mul) + CB_W'(HALF);
    assign s_raw    = cube_rnd[FRAC_BITS +: LVL_W+1];

    assign pnum  = NUM_W'(t_reg) * NUM_W'(PROG_MUL) + NUM_W'(PROG_BIAS);
    assign pprod = PP_W'(pnum) * PP_W'(PROG_RCP);

    // elapsed is below the duration here, so it seeds the remainder directly
    assign div_start = cmd.div_ratio;
    assign div_rem   = el_reg[DUR_W-1:0];
    assign div_num   = '0;
    assign div_nbits = CNT_W'(FRAC_BITS);
    assign div_dvs   = dur;

    ssfs_div #(
        .NUM_W (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .numer    (div_num),
        .nbits    (div_nbits),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_comb begin
        fade_out_next = fade_out_reg;
        fade_in_next  = fade_in_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FADE_OUT: fade_out_next = cfg_data;
                REG_FADE_IN:  fade_in_next  = cfg_data;
            endcase
        end
    end

    always_comb begin
        op_next  = op_reg;
        dt_next  = dt_reg;
        tgt_next = tgt_reg;
        if (cmd.take_item) begin
            op_next  = s_op;
            dt_next  = s_dt;
            tgt_next = s_has_target;
        end
    end

    always_comb begin
        t_next  = t_reg;
        t2_next = t2_reg;
        s_next  = s_reg;
        pq_next = pq_reg;
        if (cmd.t_one) begin
            t_next = ONE;
        end else if (cmd.take_quot) begin
            t_next = {1'b0, div_quot};
        end
        if (cmd.square) begin
            t2_next = sq_rnd[FRAC_BITS +: LVL_W];
        end
        if (cmd.cube) begin
            s_next = (s_raw > {1'b0, ONE}) ? ONE : s_raw[LVL_W-1:0];
        end
        if (cmd.scale_prog) begin
            pq_next = LVL_W'(pprod[PK +: PQ_W]);
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        el_next        = el_reg;
        alpha_next     = alpha_reg;
        prog_next      = prog_reg;
        swap_done_next = swap_done_reg;
        swap_next      = swap_reg;
        if (cmd.take_item) begin
            swap_next = 1'b0;
        end else if (cmd.start_fade) begin
            phase_next     = PH_FADE_OUT;
            el_next        = '0;
            alpha_next     = '0;
            prog_next      = '0;
            swap_done_next = 1'b0;
        end else if (cmd.add_time) begin
            el_next = el_sum[EL_W] ? EL_MAX : el_sum[EL_W-1:0];
        end else if (cmd.load_step) begin
            alpha_next = ONE;
            if (!swap_done_reg) begin
                swap_next      = 1'b1;
                swap_done_next = 1'b1;
                prog_next      = SIX_TENTHS;
            end else begin
                prog_next  = ONE;
                phase_next = PH_FADE_IN;
                el_next    = '0;
            end
        end else if (cmd.apply) begin
            if (phase_reg == PH_FADE_OUT) begin
                alpha_next = t_full ? ONE : s_reg;
                prog_next  = pq_reg;
                if (t_full) begin
                    phase_next     = PH_LOAD;
                    el_next        = '0;
                    swap_done_next = 1'b0;
                end
            end else begin
                alpha_next = t_full ? '0 : ONE - s_reg;
                prog_next  = ONE;
                if (t_full) begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_out_reg  <= FADE_TIME_RST;
            fade_in_reg   <= FADE_TIME_RST;
            phase_reg     <= PH_IDLE;
            el_reg        <= '0;
            alpha_reg     <= '0;
            prog_reg      <= '0;
            swap_done_reg <= 1'b0;
            swap_reg      <= 1'b0;
        end else begin
            fade_out_reg  <= fade_out_next;
            fade_in_reg   <= fade_in_next;
            phase_reg     <= phase_next;
            el_reg        <= el_next;
            alpha_reg     <= alpha_next;
            prog_reg      <= prog_next;
            swap_done_reg <= swap_done_next;
            swap_reg      <= swap_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        dt_reg  <= dt_next;
        tgt_reg <= tgt_next;
        t_reg   <= t_next;
        t2_reg  <= t2_next;
        s_reg   <= s_next;
        pq_reg  <= pq_next;
    end

    assign status.is_begin   = (op_reg == OP_BEGIN);
    assign status.has_target = tgt_reg;
    assign status.phase      = phase_reg;
    assign status.t_sat      = (dur == '0) || (el_reg >= {1'b0, dur});
    assign status.div_busy   = div_busy;

    assign alpha_level = alpha_reg;
    assign prog_level  = prog_reg;
    assign phase       = phase_reg;
    assign swap        = swap_reg;

endmodule

### rtl/ssfs_ctrl.sv
// Controller of the fade sequencer: sequences one item through the datapath.
// Depends on ssfs_pkg for the state, command and status types.
module ssfs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  out_free,
    input  ssfs_pkg::dp_status_t  status,
    output ssfs_pkg::dp_cmd_t     cmd
);
    import ssfs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (status.is_begin) begin
                    state_next = ST_EMIT;
                end else if (status.phase == PH_FADE_OUT || status.phase == PH_FADE_IN) begin
                    state_next = ST_RATIO;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_RATIO:  state_next = status.t_sat ? ST_SQ : ST_DIVR;
            ST_DIVR:   if (!status.div_busy) state_next = ST_SQ;
            ST_SQ:     state_next = ST_CUBE;
            ST_CUBE:   state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.take_item = s_valid;
            ST_DECODE: begin
                if (status.is_begin) begin
                    cmd.start_fade = (status.phase == PH_IDLE) && status.has_target;
                end else begin
                    unique case (status.phase)
                        PH_FADE_OUT, PH_FADE_IN: cmd.add_time  = 1'b1;
                        PH_LOAD:                 cmd.load_step = 1'b1;
                        PH_IDLE:                 cmd.add_time  = 1'b0;
                    endcase
                end
            end
            ST_RATIO: begin
                cmd.t_one     = status.t_sat;
                cmd.div_ratio = !status.t_sat;
            end
            ST_DIVR:   cmd.take_quot = !status.div_busy;
            ST_SQ:     cmd.square = 1'b1;
            ST_CUBE: begin
                cmd.cube       = 1'b1;
                cmd.scale_prog = (status.phase == PH_FADE_OUT);
            end
            ST_APPLY:  cmd.apply = 1'b1;
            ST_EMIT:   cmd.emit = out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

### rtl/smoothstep_fade_sequencer.sv
// Smoothstep fade sequencer, top level: controller, datapath and result register.
// Depends on ssfs_pkg, ssfs_ctrl and ssfs_datapath.
//
// Input channel s_*: one item per transfer, op = tick (dt elapsed) or begin.
// Result channel m_*: exactly one result per input item, in order: alpha and
// progress bytes, the phase after the item, and the swap request pulse.
// Configuration channel cfg_*: always ready; index 0 writes the fade-out time,
// index 1 the fade-in time. Write only while no item is in flight.
// Each input transfer is decoded; begin, idle and load ticks then go straight
// to the emit state, while fade ticks first pass the ratio state, the bit-serial
// divider that forms the time ratio, and the square, cube and apply states; the
// divider is skipped when the ratio saturates at one. One item is processed at a
// time; the next is taken at the earliest in the cycle after the previous result
// is loaded into the output register, even while the receiver stalls it.
// Reset returns to idle with both fade times at 500000 and all levels zero.
// A stalled receiver holds the result; the block then finishes at most one
// further item and waits for the output register to drain.
module smoothstep_fade_sequencer #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic signed [ssfs_pkg::DT_W-1:0]  s_dt,
    input  logic                              s_has_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ssfs_pkg::BYTE_W-1:0]       m_alpha,
    output logic [ssfs_pkg::BYTE_W-1:0]       m_load_progress,
    output logic [ssfs_pkg::PHASE_W-1:0]      m_phase,
    output logic                              m_swap_request,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssfs_pkg::DUR_W-1:0]        cfg_data
);
    import ssfs_pkg::*;

    localparam int LVL_W = FRAC_BITS + 1;
    localparam int MUL_W = LVL_W + BYTE_W;
    localparam int HALF  = 2 ** (FRAC_BITS - 1);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [LVL_W-1:0]    alpha_level;
    logic [LVL_W-1:0]    prog_level;
    phase_t              phase;
    logic                swap;
    logic                out_free;

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   alpha_reg, alpha_next;
    logic [BYTE_W-1:0]   prog_reg, prog_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                swap_reg, swap_next;

    // round(v * 255) with v in Q1.FRAC_BITS, v at most one
    function automatic logic [BYTE_W-1:0] to_byte(input logic [LVL_W-1:0] v);
        logic [MUL_W-1:0] scaled;
        scaled = {v, {BYTE_W{1'b0}}} - MUL_W'(v) + MUL_W'(HALF);
        return scaled[FRAC_BITS +: BYTE_W];
    endfunction

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    ssfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    ssfs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_op         (s_op),
        .s_dt         (s_dt),
        .s_has_target (s_has_target),
        .cmd          (cmd),
        .status       (status),
        .alpha_level  (alpha_level),
        .prog_level   (prog_level),
        .phase        (phase),
        .swap         (swap)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        alpha_next   = alpha_reg;
        prog_next    = prog_reg;
        phase_next   = phase_reg;
        swap_next    = swap_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            alpha_next   = to_byte(alpha_level);
            prog_next    = to_byte(prog_level);
            phase_next   = phase;
            swap_next    = swap;
        end else if (m_ready) begin
            // drop the result once transferred
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        alpha_reg <= alpha_next;
        prog_reg  <= prog_next;
        phase_reg <= phase_next;
        swap_reg  <= swap_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_alpha         = alpha_reg;
    assign m_load_progress = prog_reg;
    assign m_phase         = phase_reg;
    assign m_swap_request  = swap_reg;

`ifndef SYNTHESIS
    a_swap_only_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_swap_request) |-> (m_phase == PH_LOAD))
        else $error("swap request outside the loading phase");

    a_idle_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_phase == PH_IDLE) |-> (m_alpha == '0))
        else $error("non-zero alpha reported in idle");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("result loaded over an untransferred result");
`endif

endmodule

### tb/tb_smoothstep_fade_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the smoothstep fade sequencer: a directed walk through
// every phase, then random fade sequences under several fade-time settings.
// Depends on ssfs_pkg and the smoothstep_fade_sequencer RTL.
module tb_smoothstep_fade_sequencer;
    import ssfs_pkg::*;

    localparam int         FRAC    = 16;
    localparam bit [63:0]  ONE     = 64'd1 << FRAC;
    localparam bit [63:0]  HALF    = ONE >> 1;
    localparam int         LIMIT   = 1000000;
    localparam int         HOLDOFF = 400;
    localparam int         TAIL    = 60;

    localparam logic signed [DT_W-1:0] DT_MAX  = 17'h0FFFF;
    localparam logic signed [DT_W-1:0] DT_MIN  = 17'h10000;
    localparam logic signed [DT_W-1:0] DT_NEG1 = 17'h1FFFF;
    localparam logic [DUR_W-1:0]       DUR_TOP = {DUR_W{1'b1}};

    typedef struct packed {
        logic [BYTE_W-1:0]  alpha;
        logic [BYTE_W-1:0]  progress;
        logic [PHASE_W-1:0] ph;
        logic               swap_req;
    } fade_frame_t;

    class fade_scoreboard;
        logic [DUR_W-1:0] out_time;
        logic [DUR_W-1:0] in_time;
        phase_t           fade_ph;
        bit [EL_W-1:0]    elapsed;
        bit [FRAC:0]      alpha_q;
        bit [FRAC:0]      prog_q;
        bit               swapped;
        fade_frame_t      pending[$];
        int               errors;
        int               results;

        function new();
            out_time = FADE_TIME_RST;
            in_time  = FADE_TIME_RST;
            fade_ph  = PH_IDLE;
            elapsed  = '0;
            alpha_q  = '0;
            prog_q   = '0;
            swapped  = 1'b0;
            errors   = 0;
            results  = 0;
        endfunction

        function void set_fade_time(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] v);
            if (idx == REG_FADE_OUT)
                out_time = v;
            else if (idx == REG_FADE_IN)
                in_time = v;
        endfunction

        function bit [63:0] time_ratio(bit [63:0] el, bit [63:0] dur);
            bit [63:0] q;
            if (dur == 0 || el >= dur)
                return ONE;
            q = (el << FRAC) / dur;
            return (q > ONE) ? ONE : q;
        endfunction

        function bit [63:0] smooth(bit [63:0] t);
            bit [63:0] t2, s;
            if (t > ONE)
                t = ONE;
            t2 = (t * t + HALF) >> FRAC;
            s  = (t2 * (3 * ONE - 2 * t) + HALF) >> FRAC;
            return (s > ONE) ? ONE : s;
        endfunction

        function logic [BYTE_W-1:0] level_byte(bit [63:0] v);
            bit [63:0] b;
            if (v > ONE)
                v = ONE;
            b = (v * 255 + HALF) >> FRAC;
            return b[BYTE_W-1:0];
        endfunction

        function bit [EL_W-1:0] add_time(bit [63:0] d);
            bit [63:0] el;
            el = 64'(elapsed) + d;
            if (el > EL_MAX)
                el = EL_MAX;
            return el[EL_W-1:0];
        endfunction

        // Advance the fade state by one transfer and queue the frame it produces.
        // Returns 1 when the item does real work (not an ignored begin or idle tick).
        function bit note_item(logic op, logic signed [DT_W-1:0] dt, logic tgt);
            bit [63:0]   d, t;
            bit          live;
            fade_frame_t f;
            d = dt[DT_W-1] ? 64'd0 : 64'(dt[DT_W-2:0]);
            f.swap_req = 1'b0;
            live = (op == OP_BEGIN) ? (fade_ph == PH_IDLE && tgt) : (fade_ph != PH_IDLE);
            if (op == OP_BEGIN) begin
                if (fade_ph == PH_IDLE && tgt) begin
                    fade_ph = PH_FADE_OUT;
                    elapsed = '0;
                    alpha_q = '0;
                    prog_q  = '0;
                    swapped = 1'b0;
                end
            end else begin
                case (fade_ph)
                    PH_FADE_OUT: begin
                        elapsed = add_time(d);
                        t = time_ratio(elapsed, out_time);
                        alpha_q = smooth(t);
                        prog_q  = (PROG_MUL * t + PROG_BIAS) / PROG_DIV;
                        if (t >= ONE) begin
                            alpha_q = ONE;
                            fade_ph = PH_LOAD;
                            elapsed = '0;
                            swapped = 1'b0;
                        end
                    end
                    PH_LOAD: begin
                        alpha_q = ONE;
                        if (!swapped) begin
                            f.swap_req = 1'b1;
                            swapped = 1'b1;
                            prog_q  = (3 * ONE + 2) / 5;
                        end else begin
                            prog_q  = ONE;
                            fade_ph = PH_FADE_IN;
                            elapsed = '0;
                        end
                    end
                    PH_FADE_IN: begin
                        elapsed = add_time(d);
                        t = time_ratio(elapsed, in_time);
                        alpha_q = ONE - smooth(t);
                        prog_q  = ONE;
                        if (t >= ONE) begin
                            alpha_q = '0;
                            fade_ph = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            f.alpha    = level_byte(alpha_q);
            f.progress = level_byte(prog_q);
            f.ph       = fade_ph;
            pending.push_back(f);
            return live;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [BYTE_W-1:0] alpha, logic [BYTE_W-1:0] progress,
                          logic [PHASE_W-1:0] ph, logic swap_req);
            fade_frame_t want;
            results++;
            if (pending.size() == 0) begin
                report($sformatf("frame %0d arrived with nothing outstanding", results));
                return;
            end
            want = pending.pop_front();
            if (alpha !== want.alpha)
                report($sformatf("frame %0d alpha %0d, want %0d", results, alpha, want.alpha));
            if (progress !== want.progress)
                report($sformatf("frame %0d progress %0d, want %0d",
                                 results, progress, want.progress));
            if (ph !== want.ph)
                report($sformatf("frame %0d phase %0d, want %0d", results, ph, want.ph));
            if (swap_req !== want.swap_req)
                report($sformatf("frame %0d swap_request %0b, want %0b",
                                 results, swap_req, want.swap_req));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic                     s_op           = OP_TICK;
    logic signed [DT_W-1:0]   s_dt           = '0;
    logic                     s_has_target   = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [BYTE_W-1:0]        m_alpha;
    logic [BYTE_W-1:0]        m_load_progress;
    logic [PHASE_W-1:0]       m_phase;
    logic                     m_swap_request;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index      = REG_FADE_OUT;
    logic [DUR_W-1:0]         cfg_data       = '0;

    fade_scoreboard sb = new();
    int live_items   = 0;
    int burst_left   = 0;
    int holdoff_req  = 0;
    int holdoff_left = 0;
    int cycles       = 0;

    smoothstep_fade_sequencer #(.FRAC_BITS(FRAC)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_dt            (s_dt),
        .s_has_target    (s_has_target),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alpha         (m_alpha),
        .m_load_progress (m_load_progress),
        .m_phase         (m_phase),
        .m_swap_request  (m_swap_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Result side: check every transfer, stall on a changing pattern, and take
    // one long hold-off on request.
    initial begin : sink
        int mode, mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_alpha, m_load_progress, m_phase, m_swap_request);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else if (holdoff_req != 0) begin
                holdoff_req = 0;
                holdoff_left = HOLDOFF;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Drop valid for a random gap at the end of each burst; no gaps while the
    // receiver is held off, so the block backs up.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (holdoff_req != 0 || holdoff_left > 0)
                gap = 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic offer(input logic op, input logic signed [DT_W-1:0] dt, input logic tgt);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_dt         <= dt;
        s_has_target <= tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sb.note_item(op, dt, tgt))
            live_items++;
        pace_sender();
    endtask

    task automatic settle(input int extra);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_fade_times(input logic [DUR_W-1:0] fo, input logic [DUR_W-1:0] fi);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FADE_OUT;
        cfg_data  <= fo;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_fade_time(REG_FADE_OUT, fo);
        cfg_index <= REG_FADE_IN;
        cfg_data  <= fi;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_fade_time(REG_FADE_IN, fi);
        cfg_valid <= 1'b0;
    endtask

    // Scale most steps to the fade time so sequences finish in a sensible number of ticks.
    function automatic logic signed [DT_W-1:0] pick_dt(bit [DUR_W-1:0] dur);
        bit [DUR_W-1:0] lim;
        lim = dur / 6 + 1;
        if (lim > 24'hFFFF)
            lim = 24'hFFFF;
        case ($urandom_range(0, 9))
            0: return DT_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return DT_MIN;
                    1: return DT_NEG1;
                    2: return DT_MAX;
                    default: return '0;
                endcase
            end
            2, 3: return DT_W'($urandom_range(0, 65535));
            default: return DT_W'($urandom_range(0, lim));
        endcase
    endfunction

    task automatic random_item();
        logic                   op, tgt;
        logic signed [DT_W-1:0] dt;
        int                     r;
        r   = $urandom_range(0, 9);
        tgt = 1'($urandom_range(0, 1));
        dt  = pick_dt((sb.fade_ph == PH_FADE_IN) ? sb.in_time : sb.out_time);
        if (sb.fade_ph == PH_IDLE) begin
            op = (r < 7) ? OP_BEGIN : OP_TICK;
            if (r < 6)
                tgt = 1'b1;
        end else begin
            op = (r == 0) ? OP_BEGIN : OP_TICK;
        end
        offer(op, dt, tgt);
    endtask

    task automatic run_phase(input logic [DUR_W-1:0] fo, input logic [DUR_W-1:0] fi,
                             input int n, input bit squeeze);
        int goal;
        settle(4);
        write_fade_times(fo, fi);
        if (squeeze)
            holdoff_req = 1;
        goal = live_items + n;
        while (live_items < goal) random_item();
    endtask

    initial begin : stimulus
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk at the reset fade times
        offer(OP_TICK, DT_MAX, 1'b0);
        offer(OP_BEGIN, DT_NEG1, 1'b0);
        offer(OP_BEGIN, '0, 1'b1);
        offer(OP_BEGIN, DT_MAX, 1'b1);
        offer(OP_TICK, DT_MIN, 1'b1);
        offer(OP_TICK, DT_NEG1, 1'b0);
        repeat (8) offer(OP_TICK, DT_MAX, 1'b0);
        offer(OP_TICK, DT_MIN, 1'b1);
        offer(OP_BEGIN, DT_MAX, 1'b1);
        offer(OP_TICK, DT_MAX, 1'b0);
        repeat (8) offer(OP_TICK, DT_MAX, 1'b0);
        offer(OP_TICK, DT_MAX, 1'b1);

        run_phase('0, '0, 150, 1'b1);
        run_phase(DUR_TOP, 24'd300000, 550, 1'b0);
        run_phase('0, DUR_TOP, 550, 1'b0);
        run_phase(24'd1, 24'd1, 100, 1'b0);
        for (k = 0; k < 3; k++)
            run_phase(DUR_W'($urandom_range(0, 1 << $urandom_range(4, 20))),
                      DUR_W'($urandom_range(0, 1 << $urandom_range(4, 20))), 180, 1'b0);

        settle(TAIL);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
